### sv/fsr_pkg.sv
// ----------------------------------------------------------------------------
// fsr_pkg
// Shared widths, beat types and engine control types of the fraction sum
// reducer.
// ----------------------------------------------------------------------------
`default_nettype none

package fsr_pkg;

    localparam int NUM_W = 32;
    localparam int DEN_W = 31;
    localparam int IN_W  = 32;
    localparam int ACC_W = 64;
    localparam int CNT_W = $clog2(ACC_W + 1);

    localparam logic [ACC_W-1:0] MAXMAG = {1'b0, {(ACC_W-1){1'b1}}};

    typedef struct packed {
        logic signed [NUM_W-1:0] numerator;
        logic        [DEN_W-1:0] denominator;
        logic                    last;
    } t_in_beat;

    typedef struct packed {
        logic signed [ACC_W-1:0] integer_part;
        logic signed [ACC_W-1:0] frac_numerator;
        logic        [ACC_W-2:0] frac_denominator;
        logic                    overflow;
    } t_out_beat;

    typedef enum logic [2:0] {
        OP_DIV = 3'b001,
        OP_MUL = 3'b010,
        OP_GCD = 3'b100
    } t_eng_op;

    typedef struct packed {
        logic    start;
        t_eng_op op;
    } t_eng_req;

    typedef struct packed {
        logic idle;
        logic done;
        logic ovf;
    } t_eng_rsp;

endpackage

`default_nettype wire

### sv/fsr_engine.sv
// ----------------------------------------------------------------------------
// fsr_engine
// Shared iterative arithmetic unit: restoring divide, shift-add multiply
// with overflow detection, and binary gcd, one step per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fsr_engine (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  fsr_pkg::t_eng_req          i_req,
    input  logic [fsr_pkg::ACC_W-1:0]  i_a,
    input  logic [fsr_pkg::ACC_W-1:0]  i_b,
    output fsr_pkg::t_eng_rsp          o_rsp,
    output logic [fsr_pkg::ACC_W-1:0]  o_quo,
    output logic [fsr_pkg::ACC_W-1:0]  o_res
);
    import fsr_pkg::*;

    typedef enum logic [5:0] {
        E_IDLE = 6'b000001,
        E_DIV  = 6'b000010,
        E_MUL  = 6'b000100,
        E_GCD  = 6'b001000,
        E_GSH  = 6'b010000,
        E_DONE = 6'b100000
    } t_estate;

    t_estate          r_state, n_state;
    logic [ACC_W-1:0] r_x, n_x;
    logic [ACC_W-1:0] r_y, n_y;
    logic [ACC_W-1:0] r_z, n_z;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_ovf, n_ovf;

    logic [ACC_W:0]   div_t;
    logic [ACC_W:0]   div_d;
    logic             div_ge;
    logic [ACC_W+1:0] mul_s;
    logic             gcd_ge;
    logic [ACC_W-1:0] gcd_big;
    logic [ACC_W-1:0] gcd_sml;
    logic [ACC_W-1:0] gcd_diff;

    always_comb begin
        div_t    = {r_z, r_x[ACC_W-1]};
        div_ge   = div_t >= {1'b0, r_y};
        div_d    = div_t - {1'b0, r_y};
        mul_s    = {1'b0, r_z, 1'b0} + (r_y[ACC_W-1] ? {2'b00, r_x} : '0);
        gcd_ge   = r_x >= r_y;
        gcd_big  = gcd_ge ? r_x : r_y;
        gcd_sml  = gcd_ge ? r_y : r_x;
        gcd_diff = gcd_big - gcd_sml;
    end

    always_comb begin
        n_state = r_state;
        n_x     = r_x;
        n_y     = r_y;
        n_z     = r_z;
        n_cnt   = r_cnt;
        n_ovf   = r_ovf;
        case (r_state)
            E_IDLE: begin
                if (i_req.start) begin
                    n_x   = i_a;
                    n_y   = i_b;
                    n_z   = '0;
                    n_ovf = 1'b0;
                    case (i_req.op)
                        OP_DIV: begin
                            n_cnt   = CNT_W'(ACC_W);
                            n_state = E_DIV;
                        end
                        OP_MUL: begin
                            n_cnt   = CNT_W'(ACC_W);
                            n_state = E_MUL;
                        end
                        OP_GCD: begin
                            n_cnt   = '0;
                            n_state = E_GCD;
                        end
                        default: n_state = E_IDLE;
                    endcase
                end
            end
            E_DIV: begin
                n_z   = div_ge ? div_d[ACC_W-1:0] : div_t[ACC_W-1:0];
                n_x   = {r_x[ACC_W-2:0], div_ge};
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_state = E_DONE;
                end
            end
            E_MUL: begin
                if (r_z[ACC_W-1] || (mul_s > {2'b00, MAXMAG})) begin
                    n_ovf = 1'b1;
                end
                n_z   = mul_s[ACC_W-1:0];
                n_y   = {r_y[ACC_W-2:0], 1'b0};
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_state = E_DONE;
                end
            end
            E_GCD: begin
                if (r_x == '0) begin
                    n_z     = r_y;
                    n_state = E_GSH;
                end else if (r_y == '0) begin
                    n_z     = r_x;
                    n_state = E_GSH;
                end else if (!r_x[0] && !r_y[0]) begin
                    n_x   = {1'b0, r_x[ACC_W-1:1]};
                    n_y   = {1'b0, r_y[ACC_W-1:1]};
                    n_cnt = r_cnt + CNT_W'(1);
                end else if (!r_x[0]) begin
                    n_x = {1'b0, r_x[ACC_W-1:1]};
                end else if (!r_y[0]) begin
                    n_y = {1'b0, r_y[ACC_W-1:1]};
                end else if (gcd_ge) begin
                    n_x = gcd_diff;
                end else begin
                    n_y = gcd_diff;
                end
            end
            E_GSH: begin
                if (r_cnt == '0) begin
                    n_state = E_DONE;
                end else begin
                    n_z   = {r_z[ACC_W-2:0], 1'b0};
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            E_DONE: n_state = E_IDLE;
            default: n_state = E_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
            r_ovf   <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_ovf   <= n_ovf;
            r_cnt   <= n_cnt;
        end
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
    end

    assign o_rsp.idle = (r_state == E_IDLE);
    assign o_rsp.done = (r_state == E_DONE);
    assign o_rsp.ovf  = r_ovf;
    assign o_quo      = r_x;
    assign o_res      = r_z;

endmodule

`default_nettype wire

### sv/fraction_sum_reducer_unit.sv
// ----------------------------------------------------------------------------
// fraction_sum_reducer_unit
// Running sum of a stream of fractions, kept reduced by gcd after every
// beat, emitted as a mixed number on the beat marked last.
//
// Input channel: i_in_valid / o_in_stall carry one fraction per beat
// (signed numerator, positive denominator, last flag). Output channel:
// o_out_valid / i_out_stall carry the integer part, the signed remainder,
// the reduced denominator and a sticky overflow flag, one beat per set.
// One input beat is worked at a time on a shared divide / multiply / gcd
// engine; o_in_stall is high until its work is done. An item runs four
// divides, three multiplies and two gcds, plus one more divide on a last
// beat. A beat that overflows is dropped early. The result sits in an
// output register, so the block takes the next input beat while it waits;
// a last beat that finds that register still full waits until it is taken.
// Reset clears the sum to 0/1 and the overflow flag and empties the output
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module fraction_sum_reducer_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  fsr_pkg::t_in_beat  i_in_beat,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output fsr_pkg::t_out_beat o_out_beat
);
    import fsr_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE = 14'h0001,
        S_GCD1 = 14'h0002,
        S_BS   = 14'h0004,
        S_DS   = 14'h0008,
        S_LCD  = 14'h0010,
        S_T1   = 14'h0020,
        S_T2   = 14'h0040,
        S_ADD  = 14'h0080,
        S_GCD2 = 14'h0100,
        S_RN   = 14'h0200,
        S_RD   = 14'h0400,
        S_FIN  = 14'h0800,
        S_QR   = 14'h1000,
        S_OUT  = 14'h2000
    } t_state;

    t_state           r_state, n_state;
    logic             r_go;
    logic             r_out_valid, n_out_valid;
    t_out_beat        r_out_beat;

    logic [ACC_W-1:0] r_sum_num;
    logic [ACC_W-1:0] r_sum_den;
    logic             r_sum_neg;
    logic             r_ovf_seen;

    logic             r_nneg;
    logic [ACC_W-1:0] r_nmag;
    logic [ACC_W-1:0] r_den;
    logic             r_last;
    logic [ACC_W-1:0] r_g;
    logic [ACC_W-1:0] r_bs;
    logic [ACC_W-1:0] r_ds;
    logic [ACC_W-1:0] r_lcd;
    logic [ACC_W-1:0] r_t1;
    logic [ACC_W-1:0] r_t2;
    logic [ACC_W-1:0] r_mag;
    logic             r_neg;
    logic [ACC_W-1:0] r_new_num;

    logic [IN_W-1:0]  in_bits;
    logic             in_neg;
    logic [IN_W-1:0]  in_mag;
    logic [ACC_W-1:0] in_mag_w;
    logic [ACC_W-1:0] in_den_w;
    logic             in_bad;

    logic [ACC_W:0]   add_sum;
    logic             add_ovf;
    logic             add_ge;
    logic [ACC_W-1:0] add_diff;
    logic [ACC_W-1:0] add_mag;
    logic             add_neg;

    t_eng_req         eng_req;
    t_eng_rsp         eng_rsp;
    logic [ACC_W-1:0] eng_a;
    logic [ACC_W-1:0] eng_b;
    logic [ACC_W-1:0] eng_quo;
    logic [ACC_W-1:0] eng_res;
    logic             eng_done;
    logic             out_free;

    fsr_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (eng_req),
        .i_a     (eng_a),
        .i_b     (eng_b),
        .o_rsp   (eng_rsp),
        .o_quo   (eng_quo),
        .o_res   (eng_res)
    );

    // input beat unpacking
    always_comb begin
        in_bits  = i_in_beat.numerator[IN_W-1:0];
        in_neg   = in_bits[IN_W-1];
        in_mag   = in_neg ? (~in_bits + IN_W'(1)) : in_bits;
        in_mag_w = ACC_W'(in_mag);
        in_den_w = ACC_W'(i_in_beat.denominator[IN_W-2:0]);
        in_bad   = (in_den_w == '0) || (in_mag_w > MAXMAG) || (in_den_w > MAXMAG);
    end

    // signed add of the two scaled numerators
    always_comb begin
        add_sum  = {1'b0, r_t1} + {1'b0, r_t2};
        add_ge   = r_t1 >= r_t2;
        add_diff = add_ge ? (r_t1 - r_t2) : (r_t2 - r_t1);
        add_ovf  = 1'b0;
        if (r_sum_neg == r_nneg) begin
            add_mag = add_sum[ACC_W-1:0];
            add_neg = r_nneg;
            add_ovf = add_sum > {1'b0, MAXMAG};
        end else if (add_ge) begin
            add_mag = add_diff;
            add_neg = r_sum_neg;
        end else begin
            add_mag = add_diff;
            add_neg = r_nneg;
        end
    end

    // engine command per state
    always_comb begin
        eng_req.start = 1'b0;
        eng_req.op    = OP_DIV;
        eng_a         = r_sum_num;
        eng_b         = r_sum_den;
        case (r_state)
            S_GCD1: begin
                eng_req.start = r_go;
                eng_req.op    = OP_GCD;
                eng_a         = r_sum_den;
                eng_b         = r_den;
            end
            S_BS: begin
                eng_req.start = r_go;
                eng_a         = r_sum_den;
                eng_b         = r_g;
            end
            S_DS: begin
                eng_req.start = r_go;
                eng_a         = r_den;
                eng_b         = r_g;
            end
            S_LCD: begin
                eng_req.start = r_go;
                eng_req.op    = OP_MUL;
                eng_a         = r_bs;
                eng_b         = r_den;
            end
            S_T1: begin
                eng_req.start = r_go;
                eng_req.op    = OP_MUL;
                eng_a         = r_sum_num;
                eng_b         = r_ds;
            end
            S_T2: begin
                eng_req.start = r_go;
                eng_req.op    = OP_MUL;
                eng_a         = r_nmag;
                eng_b         = r_bs;
            end
            S_GCD2: begin
                eng_req.start = r_go;
                eng_req.op    = OP_GCD;
                eng_a         = r_mag;
                eng_b         = r_lcd;
            end
            S_RN: begin
                eng_req.start = r_go;
                eng_a         = r_mag;
                eng_b         = r_g;
            end
            S_RD: begin
                eng_req.start = r_go;
                eng_a         = r_lcd;
                eng_b         = r_g;
            end
            S_QR: begin
                eng_req.start = r_go;
                eng_a         = r_sum_num;
                eng_b         = r_sum_den;
            end
            default: eng_req.start = 1'b0;
        endcase
    end

    assign eng_done = eng_rsp.done && !r_go;
    assign out_free = !r_out_valid || !i_out_stall;

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_in_valid) n_state = in_bad ? S_FIN : S_GCD1;
            S_GCD1: if (eng_done) n_state = S_BS;
            S_BS:   if (eng_done) n_state = S_DS;
            S_DS:   if (eng_done) n_state = S_LCD;
            S_LCD:  if (eng_done) n_state = eng_rsp.ovf ? S_FIN : S_T1;
            S_T1:   if (eng_done) n_state = eng_rsp.ovf ? S_FIN : S_T2;
            S_T2:   if (eng_done) n_state = eng_rsp.ovf ? S_FIN : S_ADD;
            S_ADD:  n_state = add_ovf ? S_FIN : S_GCD2;
            S_GCD2: if (eng_done) n_state = S_RN;
            S_RN:   if (eng_done) n_state = S_RD;
            S_RD:   if (eng_done) n_state = S_FIN;
            S_FIN:  n_state = r_last ? S_QR : S_IDLE;
            S_QR:   if (eng_done) n_state = S_OUT;
            S_OUT:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if ((r_state == S_OUT) && out_free) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_go        <= 1'b0;
            r_out_valid <= 1'b0;
            r_sum_num   <= '0;
            r_sum_den   <= ACC_W'(1);
            r_sum_neg   <= 1'b0;
            r_ovf_seen  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_go        <= (n_state != r_state);
            r_out_valid <= n_out_valid;
            case (r_state)
                S_IDLE: if (i_in_valid && in_bad) r_ovf_seen <= 1'b1;
                S_LCD, S_T1, S_T2: if (eng_done && eng_rsp.ovf) r_ovf_seen <= 1'b1;
                S_ADD: if (add_ovf) r_ovf_seen <= 1'b1;
                S_RD: begin
                    if (eng_done) begin
                        r_sum_num <= r_new_num;
                        r_sum_den <= eng_quo;
                        r_sum_neg <= (r_new_num != '0) && r_neg;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_sum_num  <= '0;
                        r_sum_den  <= ACC_W'(1);
                        r_sum_neg  <= 1'b0;
                        r_ovf_seen <= 1'b0;
                    end
                end
                default: r_ovf_seen <= r_ovf_seen;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    r_nneg <= in_neg;
                    r_nmag <= in_mag_w;
                    r_den  <= in_den_w;
                    r_last <= i_in_beat.last;
                end
            end
            S_GCD1: if (eng_done) r_g <= eng_res;
            S_BS:   if (eng_done) r_bs <= eng_quo;
            S_DS:   if (eng_done) r_ds <= eng_quo;
            S_LCD:  if (eng_done) r_lcd <= eng_res;
            S_T1:   if (eng_done) r_t1 <= eng_res;
            S_T2:   if (eng_done) r_t2 <= eng_res;
            S_ADD: begin
                r_mag <= add_mag;
                r_neg <= add_neg;
            end
            S_GCD2: if (eng_done) r_g <= eng_res;
            S_RN:   if (eng_done) r_new_num <= eng_quo;
            S_OUT: begin
                if (out_free) begin
                    r_out_beat.integer_part   <= r_sum_neg ? (~eng_quo + ACC_W'(1)) : eng_quo;
                    r_out_beat.frac_numerator <= r_sum_neg ? (~eng_res + ACC_W'(1)) : eng_res;
                    r_out_beat.frac_denominator <= (eng_res == '0) ? (ACC_W-1)'(1)
                                                                   : r_sum_den[ACC_W-2:0];
                    r_out_beat.overflow       <= r_ovf_seen;
                end
            end
            default: r_last <= r_last;
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    // the running denominator is never zero and both magnitudes stay in range
    a_sum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sum_den != '0) && !r_sum_den[ACC_W-1] && !r_sum_num[ACC_W-1])
        else $error("running sum out of range");

    // engine is only started when it is free
    a_eng_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eng_req.start |-> eng_rsp.idle)
        else $error("engine started while busy");

    // a delivered result always has a nonzero denominator
    a_out_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_beat.frac_denominator != '0))
        else $error("result with zero denominator");

    // loading a result clears the sum for the next set
    a_sum_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_OUT) && out_free) |=>
        ((r_sum_num == '0) && (r_sum_den == ACC_W'(1)) && !r_ovf_seen && o_out_valid))
        else $error("sum not cleared after result");

endmodule

`default_nettype wire
